// ===== src/ili_pkg.sv =====
package ili_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int COORD_BITS = 16;
    localparam int T_W        = COORD_BITS + 2;   // b - 1 - a, signed
    localparam int DIFF_W     = COORD_BITS + 1;   // f - d and c - a, signed
    localparam int SPAN_W     = COORD_BITS + 1;   // absolute spans, unsigned
    localparam int ERR_W      = SPAN_W + 1;       // error term, signed
    localparam int E_W        = SPAN_W + 2;       // error term plus span, signed
    localparam int EQ_W       = SPAN_W + 1;       // positive part of e, step dividend
    localparam int PROD_W     = 2 * SPAN_W;       // |t| * |f - d|, start dividend
    localparam int CNT_W      = $clog2(PROD_W + 1);
    localparam int CUR_W      = 36;               // stored interpolated value
    localparam int VALUE_W    = 32;               // emitted value

    // Microcode layout.
    localparam int UPC_W  = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_PREP  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_SFIN  = 4'd4;
    localparam logic [OP_W-1:0] OP_ZFIN  = 4'd5;
    localparam logic [OP_W-1:0] OP_ESUM  = 4'd6;
    localparam logic [OP_W-1:0] OP_DLOAD = 4'd7;
    localparam logic [OP_W-1:0] OP_APPQ  = 4'd8;
    localparam logic [OP_W-1:0] OP_APP1  = 4'd9;
    localparam logic [OP_W-1:0] OP_KEEP  = 4'd10;
    localparam logic [OP_W-1:0] OP_EMIT  = 4'd11;

    // Jump conditions.
    localparam logic [COND_W-1:0] C_NEVER   = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS  = 4'd1;
    localparam logic [COND_W-1:0] C_NOFIRE  = 4'd2;
    localparam logic [COND_W-1:0] C_ISSTEP  = 4'd3;
    localparam logic [COND_W-1:0] C_CAZERO  = 4'd4;
    localparam logic [COND_W-1:0] C_DIVMORE = 4'd5;
    localparam logic [COND_W-1:0] C_NOSTEP  = 4'd6;
    localparam logic [COND_W-1:0] C_ELT     = 4'd7;
    localparam logic [COND_W-1:0] C_ELT2    = 4'd8;
    localparam logic [COND_W-1:0] C_OBUSY   = 4'd9;

    typedef struct packed {
        logic                  take;    // input channel open in this step
        logic [OP_W-1:0]       op;
        logic [COND_W-1:0]     cond;
        logic [UPC_W-1:0]      target;
        logic                  fin;     // fall through to the idle step
    } cw_t;

    typedef struct packed {
        logic no_fire;
        logic is_step;
        logic ca_zero;
        logic div_more;
        logic no_step;
        logic e_lt;
        logic e_lt2;
        logic out_busy;
    } flags_t;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] src_start;
        logic signed [COORD_BITS-1:0] src_pos;
        logic signed [COORD_BITS-1:0] src_end;
        logic signed [COORD_BITS-1:0] dst_start;
        logic signed [COORD_BITS-1:0] dst_end;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      fault;
    } result_t;

endpackage

// ===== src/incremental_linear_interpolator_top.sv =====
// Incremental linear interpolator: a DDA stepper that walks a value linearly
// across a span, one source position per step, as a rasterizer does per column.
// The item channel (item_valid, item_ready, item) carries start and step beats.
// A start beat maps src_start..src_end onto dst_start..dst_end, places the
// stepper one position before src_pos, and produces no result. A step beat
// advances one position and produces one result beat (value, fault) on the
// result channel (result_valid, result_ready, result).
// A start beat runs one 17x17 multiply, then a shift-subtract divide of the
// 34-bit product on the shared divider; both are skipped when the source width
// is zero. A step beat goes straight to the emit step when the stepper is faulted
// or unstarted, keeps the value when it does not move, adds one when it moves by
// one, and divides the 18-bit error term when it moves by more than one. The
// result is registered and appears the cycle after the emit step. The item
// channel is open only in the idle step, so no item is taken while one is in work.
// Reset clears the stepper to value zero, no fault, zero spans. A result waits
// in its output register while result_ready is low; the next item is still
// accepted and processed, and its own result waits in the emit step.
module incremental_linear_interpolator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ili_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ili_pkg::result_t result
);
    import ili_pkg::*;

    // Control from the microcode sequencer and status back to it.
    cw_t    cw;
    flags_t flags;

    // Captured input beat.
    item_t in_reg;
    logic  fire;

    // Stepper state.
    logic signed [CUR_W-1:0] cur_reg;
    logic signed [CUR_W-1:0] cur_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic [SPAN_W-1:0]       dspan_reg;
    logic [SPAN_W-1:0]       sspan_reg;
    logic                    neg_reg;
    logic                    fault_reg;

    // Start scratch: operand magnitude and result signs.
    logic [SPAN_W-1:0] tabs_reg;
    logic              tneg_reg;
    logic              qneg_reg;

    // Step scratch: error term plus destination span.
    logic signed [E_W-1:0] e_reg;
    logic signed [E_W-1:0] e_sum;

    // Shared shift-subtract divider.
    logic [PROD_W-1:0] dvd_reg;
    logic [PROD_W-1:0] dvd_next;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] rem_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [SPAN_W:0]   div_sh;
    logic [SPAN_W:0]   div_diff;
    logic              div_ge;

    // Output register.
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_busy;

    // Start decode.
    logic signed [T_W-1:0]    t_val;
    logic signed [DIFF_W-1:0] fd_val;
    logic signed [DIFF_W-1:0] ca_val;
    logic [SPAN_W-1:0]        t_abs;
    logic [SPAN_W-1:0]        fd_abs;
    logic [SPAN_W-1:0]        ca_abs;

    // Value update through one saturating adder.
    logic signed [CUR_W-1:0] add_base;
    logic signed [CUR_W:0]   add_delta;
    logic signed [CUR_W-1:0] add_sum;
    logic signed [CUR_W:0]   mag;

    function automatic logic signed [CUR_W-1:0] sat_add(
        input logic signed [CUR_W-1:0] base,
        input logic signed [CUR_W:0]   delta
    );
        logic signed [CUR_W+1:0] s;
        logic signed [CUR_W-1:0] r;
        s = {{2{base[CUR_W-1]}}, base} + {delta[CUR_W], delta};
        if ((s[CUR_W+1:CUR_W-1] == 3'b000) || (s[CUR_W+1:CUR_W-1] == 3'b111))
        begin
            r = s[CUR_W-1:0];
        end
        else if (s[CUR_W+1])
        begin
            r = {1'b1, {(CUR_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CUR_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_out(input logic signed [CUR_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if ((v[CUR_W-1:VALUE_W-1] == '0) || (v[CUR_W-1:VALUE_W-1] == '1))
        begin
            r = v[VALUE_W-1:0];
        end
        else if (v[CUR_W-1])
        begin
            r = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return r;
    endfunction

    ili_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    assign item_ready   = cw.take;
    assign fire         = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_busy     = out_valid_reg && !result_ready;

    // Start decode: t = b - 1 - a, spans and their magnitudes.
    always_comb
    begin
        t_val  = T_W'(in_reg.src_pos) - T_W'(1) - T_W'(in_reg.src_start);
        fd_val = DIFF_W'(in_reg.dst_end) - DIFF_W'(in_reg.dst_start);
        ca_val = DIFF_W'(in_reg.src_end) - DIFF_W'(in_reg.src_start);
        t_abs  = t_val[T_W-1]     ? SPAN_W'(-t_val)  : SPAN_W'(t_val);
        fd_abs = fd_val[DIFF_W-1] ? SPAN_W'(-fd_val) : SPAN_W'(fd_val);
        ca_abs = ca_val[DIFF_W-1] ? SPAN_W'(-ca_val) : SPAN_W'(ca_val);
    end

    assign e_sum = E_W'(err_reg) + $signed({1'b0, dspan_reg});

    // One restoring divide iteration: quotient bits shift in at the bottom.
    always_comb
    begin
        div_sh   = {rem_reg, dvd_reg[PROD_W-1]};
        div_ge   = div_sh >= {1'b0, sspan_reg};
        div_diff = div_sh - {1'b0, sspan_reg};
    end

    always_comb
    begin
        flags.no_fire  = !fire;
        flags.is_step  = in_reg.req_type;
        flags.ca_zero  = (ca_val == '0);
        flags.div_more = (cnt_reg != CNT_W'(1));
        flags.no_step  = fault_reg || (sspan_reg == '0);
        flags.e_lt     = e_reg < $signed({1'b0, sspan_reg});
        flags.e_lt2    = e_reg < $signed({1'b0, sspan_reg, 1'b0});
        flags.out_busy = out_busy;
    end

    // Operands of the saturating adder: the start value is d plus the signed
    // quotient, a step moves the current value by the whole spans crossed.
    always_comb
    begin
        add_base  = cur_reg;
        add_delta = '0;
        mag       = '0;
        unique case (cw.op)
            OP_SFIN:
            begin
                add_base  = CUR_W'(in_reg.dst_start);
                mag       = (CUR_W+1)'(dvd_reg);
                add_delta = qneg_reg ? -mag : mag;
            end
            OP_APPQ:
            begin
                mag       = (CUR_W+1)'(dvd_reg[EQ_W-1:0]);
                add_delta = neg_reg ? -mag : mag;
            end
            OP_APP1:
            begin
                mag       = (CUR_W+1)'(1);
                add_delta = neg_reg ? -mag : mag;
            end
            default:
            begin
                add_base  = cur_reg;
                add_delta = '0;
            end
        endcase
        add_sum = sat_add(add_base, add_delta);
    end

    always_comb
    begin
        cur_next       = cur_reg;
        err_next       = err_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (cw.op)
            OP_MUL:
            begin
                dvd_next = tabs_reg * dspan_reg;
                rem_next = '0;
                cnt_next = CNT_W'(PROD_W);
            end
            OP_DIV:
            begin
                dvd_next = {dvd_reg[PROD_W-2:0], div_ge};
                rem_next = div_ge ? div_diff[SPAN_W-1:0] : div_sh[SPAN_W-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            OP_SFIN:
            begin
                cur_next = add_sum;
                err_next = tneg_reg ? -ERR_W'(rem_reg) : ERR_W'(rem_reg);
            end
            OP_ZFIN:
            begin
                cur_next = CUR_W'(in_reg.dst_start);
                err_next = '0;
            end
            OP_DLOAD:
            begin
                dvd_next = {e_reg[EQ_W-1:0], (PROD_W-EQ_W)'(0)};
                rem_next = '0;
                cnt_next = CNT_W'(EQ_W);
            end
            OP_APPQ:
            begin
                cur_next = add_sum;
                err_next = ERR_W'(rem_reg);
            end
            OP_APP1:
            begin
                cur_next = add_sum;
                err_next = ERR_W'(e_reg - $signed({1'b0, sspan_reg}));
            end
            OP_KEEP:
            begin
                err_next = ERR_W'(e_reg);
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            err_reg       <= '0;
            dspan_reg     <= '0;
            sspan_reg     <= '0;
            neg_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cw.op == OP_PREP)
            begin
                dspan_reg <= fd_abs;
                sspan_reg <= ca_abs;
                neg_reg   <= (in_reg.dst_end < in_reg.dst_start) !=
                             (in_reg.src_end < in_reg.src_start);
                fault_reg <= (ca_val == '0);
            end
        end
    end

    // Payload and scratch registers need no reset.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            in_reg <= item;
        end
        if (cw.op == OP_PREP)
        begin
            tabs_reg <= t_abs;
            tneg_reg <= t_val[T_W-1];
            qneg_reg <= t_val[T_W-1] ^ fd_val[DIFF_W-1] ^ ca_val[DIFF_W-1];
        end
        if (cw.op == OP_ESUM)
        begin
            e_reg <= e_sum;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if ((cw.op == OP_EMIT) && !out_busy)
        begin
            out_reg.value <= sat_out(cur_reg);
            out_reg.fault <= fault_reg;
        end
    end

    // A new result beat is raised only by the emit step.
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cw.op == OP_EMIT))
        else $error("result beat raised outside the emit step");

    // A faulted stepper never moves its value.
    a_fault_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fault_reg && ((cw.op == OP_APPQ) || (cw.op == OP_APP1))))
        else $error("value moved while the span is faulted");

    // The divider's partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_DIV) |=> (rem_reg < sspan_reg))
        else $error("divider remainder out of range");

    // When waiting for an item, the error term lies strictly inside the span.
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.take && !fault_reg && (sspan_reg != '0)) |->
        ((err_reg < $signed({1'b0, sspan_reg})) && (-err_reg < $signed({1'b0, sspan_reg}))))
        else $error("error term outside the source span");

endmodule

// ===== src/ili_useq.sv =====
module ili_useq (
    input  logic           clk,
    input  logic           rst_n,
    input  ili_pkg::flags_t flags,
    output ili_pkg::cw_t    cw
);
    import ili_pkg::*;

    // Program addresses.
    localparam logic [UPC_W-1:0] A_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] A_DISP  = 4'd1;
    localparam logic [UPC_W-1:0] A_PREP  = 4'd2;
    localparam logic [UPC_W-1:0] A_MUL   = 4'd3;
    localparam logic [UPC_W-1:0] A_SDIV  = 4'd4;
    localparam logic [UPC_W-1:0] A_SFIN  = 4'd5;
    localparam logic [UPC_W-1:0] A_ZFIN  = 4'd6;
    localparam logic [UPC_W-1:0] A_ESUM  = 4'd7;
    localparam logic [UPC_W-1:0] A_TEST  = 4'd8;
    localparam logic [UPC_W-1:0] A_DLOAD = 4'd9;
    localparam logic [UPC_W-1:0] A_QDIV  = 4'd10;
    localparam logic [UPC_W-1:0] A_APPQ  = 4'd11;
    localparam logic [UPC_W-1:0] A_APP1  = 4'd12;
    localparam logic [UPC_W-1:0] A_KEEP  = 4'd13;
    localparam logic [UPC_W-1:0] A_EMIT  = 4'd14;
    localparam logic [UPC_W-1:0] A_SPARE = 4'd15;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    function automatic cw_t rom(input logic [UPC_W-1:0] a);
        cw_t w;
        w = '{take: 1'b0, op: OP_NONE, cond: C_NEVER, target: A_IDLE, fin: 1'b0};
        unique case (a)
            A_IDLE:  w = '{take: 1'b1, op: OP_NONE,  cond: C_NOFIRE,  target: A_IDLE,
                           fin: 1'b0};
            A_DISP:  w = '{take: 1'b0, op: OP_NONE,  cond: C_ISSTEP,  target: A_ESUM,
                           fin: 1'b0};
            A_PREP:  w = '{take: 1'b0, op: OP_PREP,  cond: C_CAZERO,  target: A_ZFIN,
                           fin: 1'b0};
            A_MUL:   w = '{take: 1'b0, op: OP_MUL,   cond: C_NEVER,   target: A_IDLE,
                           fin: 1'b0};
            A_SDIV:  w = '{take: 1'b0, op: OP_DIV,   cond: C_DIVMORE, target: A_SDIV,
                           fin: 1'b0};
            A_SFIN:  w = '{take: 1'b0, op: OP_SFIN,  cond: C_NEVER,   target: A_IDLE,
                           fin: 1'b1};
            A_ZFIN:  w = '{take: 1'b0, op: OP_ZFIN,  cond: C_NEVER,   target: A_IDLE,
                           fin: 1'b1};
            A_ESUM:  w = '{take: 1'b0, op: OP_ESUM,  cond: C_NOSTEP,  target: A_EMIT,
                           fin: 1'b0};
            A_TEST:  w = '{take: 1'b0, op: OP_NONE,  cond: C_ELT,     target: A_KEEP,
                           fin: 1'b0};
            A_DLOAD: w = '{take: 1'b0, op: OP_DLOAD, cond: C_ELT2,    target: A_APP1,
                           fin: 1'b0};
            A_QDIV:  w = '{take: 1'b0, op: OP_DIV,   cond: C_DIVMORE, target: A_QDIV,
                           fin: 1'b0};
            A_APPQ:  w = '{take: 1'b0, op: OP_APPQ,  cond: C_ALWAYS,  target: A_EMIT,
                           fin: 1'b0};
            A_APP1:  w = '{take: 1'b0, op: OP_APP1,  cond: C_ALWAYS,  target: A_EMIT,
                           fin: 1'b0};
            A_KEEP:  w = '{take: 1'b0, op: OP_KEEP,  cond: C_NEVER,   target: A_IDLE,
                           fin: 1'b0};
            A_EMIT:  w = '{take: 1'b0, op: OP_EMIT,  cond: C_OBUSY,   target: A_EMIT,
                           fin: 1'b1};
            A_SPARE: w = '{take: 1'b0, op: OP_NONE,  cond: C_ALWAYS,  target: A_IDLE,
                           fin: 1'b0};
        endcase
        return w;
    endfunction

    assign cw = rom(upc_reg);

    always_comb
    begin
        jump = 1'b0;
        unique case (cw.cond)
            C_NEVER:   jump = 1'b0;
            C_ALWAYS:  jump = 1'b1;
            C_NOFIRE:  jump = flags.no_fire;
            C_ISSTEP:  jump = flags.is_step;
            C_CAZERO:  jump = flags.ca_zero;
            C_DIVMORE: jump = flags.div_more;
            C_NOSTEP:  jump = flags.no_step;
            C_ELT:     jump = flags.e_lt;
            C_ELT2:    jump = flags.e_lt2;
            C_OBUSY:   jump = flags.out_busy;
            default:   jump = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (jump)
        begin
            upc_next = cw.target;
        end
        else if (cw.fin)
        begin
            upc_next = A_IDLE;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
